>>> rtl/gray_mingle_noise_oscillator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the noise oscillator
// Concurrent assertion wrappers; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef GRAY_MINGLE_NOISE_OSCILLATOR_MACROS_SVH
`define GRAY_MINGLE_NOISE_OSCILLATOR_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every rising clock edge outside of reset.
`define GMNO_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define GMNO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define GMNO_ASSERT(lbl, clk, rst, prop, msg)
`define GMNO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/gmno_pkg.sv
// ----------------------------------------------------------------------------
// Noise oscillator package
// Shared widths, constants and the waveform shaping functions.
// ----------------------------------------------------------------------------
package gmno_pkg;

   localparam int unsigned PHASE_W   = 16;
   localparam int unsigned STEP_W    = 32;
   localparam int unsigned FRAC_W    = 24;
   localparam int unsigned COUNTER_W = 32;
   localparam int unsigned MAG_W     = 16;
   localparam int unsigned SAMPLE_W  = 5;
   localparam int unsigned WHOLE_W   = STEP_W + 1 - FRAC_W;

   localparam logic [MAG_W-1:0] MINGLE_RESET = 16'd57;
   localparam logic [7:0]       MINGLE_ODD   = 8'hAA;
   localparam logic [7:0]       MINGLE_EVEN  = 8'h55;
   localparam logic [1:0]       SEL_LOW      = 2'd0;
   localparam logic [1:0]       SEL_HIGH     = 2'd1;

   typedef logic [MAG_W-1:0]           mag_type;
   typedef logic [PHASE_W-1:0]         phase_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

   function automatic logic [3:0] gray_decode4(input logic [3:0] g);
      logic [3:0] v;
      v = g ^ (g >> 1);
      v = v ^ (v >> 2);
      return v;
   endfunction

   // Gray code of the product, low byte with alternate bits inverted by parity.
   function automatic logic [7:0] mingle_byte(input mag_type prod);
      mag_type gray;
      gray = prod ^ (prod >> 1);
      return prod[0] ? (gray[7:0] ^ MINGLE_ODD) : (gray[7:0] ^ MINGLE_EVEN);
   endfunction

   // Nibble pick mirrored over the cycle, decoded and scaled to an odd level.
   function automatic sample_type shape_sample(input logic [7:0] mingled,
                                               input phase_type  phase);
      logic [1:0] sel;
      logic [3:0] nib;
      logic [3:0] n;
      logic [4:0] twice;
      sel = phase[PHASE_W-1] ? ~phase[14:13] : phase[14:13];
      unique case (sel)
         SEL_LOW:  nib = mingled[3:0];
         SEL_HIGH: nib = mingled[7:4];
         default:  nib = 4'd0;
      endcase
      n     = gray_decode4(nib);
      twice = {n, 1'b0};
      return phase[PHASE_W-1] ? sample_type'(twice - 5'd15)
                              : sample_type'(5'd15 - twice);
   endfunction

endpackage

>>> rtl/gray_mingle_noise_oscillator.sv
// ----------------------------------------------------------------------------
// Gray mingle noise oscillator
// Noise-chip style oscillator producing one signed sample level per item.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_stall) carries a waveform phase and a
// signed phase step with 24 fractional bits. The response channel (rsp_valid,
// rsp_stall) returns one sample level per item, the sample times 15.
// An item is taken at a rising edge with valid high and stall low.
// The sample of an item is shaped from the step counter as it stood before
// that item; the item's phase step then advances the counter and fraction.
// rsp_valid rises once the item has moved from the input register into the
// result register; the level is taken at an edge with rsp_stall low. One item
// is accepted every cycle while the receiver does not stall; the rate is set
// by the counter update and the 16 by 16 multiplier between the two registers.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more item if it is empty, after which req_stall rises.
// The csr channel writes the mingle factor; it is always ready and should be
// written only while no item is in flight. Synchronous reset empties the
// pipeline, clears the counter and fraction and loads a mingle factor of 57.
// ----------------------------------------------------------------------------
module gray_mingle_noise_oscillator
   import gmno_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [MAG_W-1:0]           csr_mingle_factor,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [PHASE_W-1:0]         req_wave_phase,
   input  logic signed [STEP_W-1:0]   req_phase_step,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_numerator
);

   mag_type mingle_factor_ff;
   mag_type magnitude;
   logic    req_accept;

   // The configuration register is always able to take a write.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mingle_factor_ff <= MINGLE_RESET;
      end else if (csr_valid && csr_ready) begin
         mingle_factor_ff <= csr_mingle_factor;
      end
   end

   // The accumulator advances exactly when the shaper takes an item.
   assign req_accept = req_valid && !req_stall;

   gmno_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .phase_step (req_phase_step),
      .magnitude  (magnitude)
   );

   gmno_shaper u_shaper (
      .clock         (clock),
      .reset         (reset),
      .mingle_factor (mingle_factor_ff),
      .in_valid      (req_valid),
      .in_stall      (req_stall),
      .in_magnitude  (magnitude),
      .in_phase      (req_wave_phase),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .out_sample    (rsp_sample_numerator)
   );

endmodule

>>> rtl/gmno_accum.sv
// ----------------------------------------------------------------------------
// Noise oscillator step accumulator
// Holds the signed step counter and the phase fraction, and gives the
// counter magnitude that the next item is shaped from.
// ----------------------------------------------------------------------------
module gmno_accum
   import gmno_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic signed [STEP_W-1:0] phase_step,
   output mag_type                  magnitude
);

   logic [COUNTER_W-1:0] counter_ff, counter_in;
   logic [FRAC_W-1:0]    frac_ff, frac_in;
   logic [STEP_W:0]      sum;
   logic [WHOLE_W-1:0]   whole;

   // Fraction plus step in 33 bits; the bits above the fraction are the floor.
   assign sum = {{(STEP_W + 1 - FRAC_W){1'b0}}, frac_ff} + {phase_step[STEP_W-1], phase_step};
   assign whole      = sum[STEP_W:FRAC_W];
   assign frac_in    = sum[FRAC_W-1:0];
   assign counter_in = counter_ff + {{(COUNTER_W - WHOLE_W){whole[WHOLE_W-1]}}, whole};

   assign magnitude = counter_ff[COUNTER_W-1] ? (mag_type'(0) - counter_ff[MAG_W-1:0])
                                              : counter_ff[MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         frac_ff    <= '0;
      end else if (accept) begin
         counter_ff <= counter_in;
         frac_ff    <= frac_in;
      end
   end

endmodule

>>> rtl/gmno_shaper.sv
// ----------------------------------------------------------------------------
// Noise oscillator waveform shaper
// Two-register pipeline: the input register holds magnitude and phase, the
// result register holds the shaped sample, with stall handling on both sides.
// ----------------------------------------------------------------------------
`include "gray_mingle_noise_oscillator_macros.svh"

module gmno_shaper
   import gmno_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  mag_type    mingle_factor,
   input  logic       in_valid,
   output logic       in_stall,
   input  mag_type    in_magnitude,
   input  phase_type  in_phase,
   output logic       out_valid,
   input  logic       out_stall,
   output sample_type out_sample
);

   logic        s1_valid_ff, s1_valid_in;
   mag_type     mag_ff;
   phase_type   phase_ff;
   logic        s2_valid_ff, s2_valid_in;
   sample_type  sample_ff;
   logic        s1_adv, s2_adv, accept;
   mag_type     prod;

   assign s2_adv   = !s2_valid_ff || !out_stall;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_stall = !s1_adv;
   assign accept   = in_valid && s1_adv;

   // Only the low 16 bits of the product are ever used.
   assign prod = mag_ff * mingle_factor;

   assign s1_valid_in = s1_adv ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mag_ff   <= in_magnitude;
         phase_ff <= in_phase;
      end
      if (s2_adv && s1_valid_ff) begin
         sample_ff <= shape_sample(mingle_byte(prod), phase_ff);
      end
   end

   assign out_valid  = s2_valid_ff;
   assign out_sample = sample_ff;

   `GMNO_ASSERT(a_sample_odd, clock, reset, !s2_valid_ff || sample_ff[0], "sample level is even")
   `GMNO_ASSERT(a_sample_range, clock, reset, !s2_valid_ff || (sample_ff != -5'sd16), "sample out of range")
   `GMNO_ASSERT_NEXT(a_s1_held, clock, reset, s1_valid_ff && !s2_adv, s1_valid_ff && $stable(mag_ff) && $stable(phase_ff), "input register lost a stalled item")
   `GMNO_ASSERT_NEXT(a_s2_filled, clock, reset, s1_valid_ff && s2_adv, s2_valid_ff, "result register missed an item")

endmodule
